FILE: rtl/ahct_pkg.sv
// ----------------------------------------------------------------------------
// ahct_pkg
// Shared types and constants for the address hit counter with trace buffer.
// ----------------------------------------------------------------------------
package ahct_pkg;

    localparam int unsigned TABLE_ENTRIES_DEF = 128;
    localparam int unsigned TRACE_DEPTH_DEF   = 1024;

    localparam int unsigned OP_W   = 2;
    localparam int unsigned ADDR_W = 32;
    localparam int unsigned IDX_W  = 10;
    localparam int unsigned CNT_W  = 32;
    localparam int unsigned LEN_W  = 11;
    localparam int unsigned USED_W = 8;

    typedef enum logic [OP_W-1:0] {
        OP_RECORD = 2'd0,
        OP_QUERY  = 2'd1,
        OP_TRACE  = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_TRACE,
        ST_FINISH
    } ctl_state_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;   // take the request beat into the datapath
        logic search;   // step the table scan
        logic finish;   // commit updates and load the result register
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic search_done;  // key found or table exhausted
        logic out_free;     // result register can take a new beat
    } dp_sts_t;

endpackage

FILE: rtl/ahct_ram.sv
// ----------------------------------------------------------------------------
// ahct_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ahct_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 128,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: rtl/ahct_ctrl.sv
// ----------------------------------------------------------------------------
// ahct_ctrl
// Sequencer: accept, scan the table or fetch a trace entry (clear does neither), then commit.
// ----------------------------------------------------------------------------
module ahct_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  logic [1:0]        op,
    input  ahct_pkg::dp_sts_t sts,
    output ahct_pkg::dp_cmd_t cmd
);

    ahct_pkg::ctl_state_t state_reg;
    ahct_pkg::ctl_state_t state_next;
    ahct_pkg::op_t        req_op;

    assign req_op = ahct_pkg::op_t'(op);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ahct_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ahct_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    unique case (req_op)
                        ahct_pkg::OP_RECORD,
                        ahct_pkg::OP_QUERY: state_next = ahct_pkg::ST_SEARCH;
                        ahct_pkg::OP_TRACE: state_next = ahct_pkg::ST_TRACE;
                        ahct_pkg::OP_CLEAR: state_next = ahct_pkg::ST_FINISH;
                        default:            state_next = ahct_pkg::ST_FINISH;
                    endcase
                end
            end
            ahct_pkg::ST_SEARCH:
            begin
                if (sts.search_done)
                begin
                    state_next = ahct_pkg::ST_FINISH;
                end
            end
            ahct_pkg::ST_TRACE:
            begin
                state_next = ahct_pkg::ST_FINISH;
            end
            ahct_pkg::ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    state_next = ahct_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ahct_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        req_ready  = (state_reg == ahct_pkg::ST_IDLE);
        cmd.accept = (state_reg == ahct_pkg::ST_IDLE) && req_valid;
        cmd.search = (state_reg == ahct_pkg::ST_SEARCH);
        cmd.finish = (state_reg == ahct_pkg::ST_FINISH) && sts.out_free;
    end

endmodule

FILE: rtl/ahct_dp.sv
// ----------------------------------------------------------------------------
// ahct_dp
// Datapath: key/count/trace RAMs, scan pointer, counters, result register.
// ----------------------------------------------------------------------------
module ahct_dp #(
    parameter int unsigned TABLE_ENTRIES = ahct_pkg::TABLE_ENTRIES_DEF,
    parameter int unsigned TRACE_DEPTH   = ahct_pkg::TRACE_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ahct_pkg::dp_cmd_t            cmd,
    output ahct_pkg::dp_sts_t            sts,
    input  logic [ahct_pkg::OP_W-1:0]    op,
    input  logic [ahct_pkg::ADDR_W-1:0]  event_address,
    input  logic [ahct_pkg::IDX_W-1:0]   entry_index,
    output logic                         rsp_valid,
    input  logic                         rsp_ready,
    output logic [ahct_pkg::CNT_W-1:0]   hit_count,
    output logic                         not_counted,
    output logic [ahct_pkg::ADDR_W-1:0]  trace_data,
    output logic                         trace_valid,
    output logic [ahct_pkg::LEN_W-1:0]   trace_length,
    output logic [ahct_pkg::CNT_W-1:0]   dropped_total,
    output logic [ahct_pkg::USED_W-1:0]  entries_used
);

    localparam int unsigned UW  = $clog2(TABLE_ENTRIES + 1);
    localparam int unsigned FW  = $clog2(TRACE_DEPTH + 1);
    localparam int unsigned TAW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int unsigned TRW = (TRACE_DEPTH > 1) ? $clog2(TRACE_DEPTH) : 1;

    // request capture
    ahct_pkg::op_t                op_reg;
    logic [ahct_pkg::ADDR_W-1:0]  addr_reg;
    logic [ahct_pkg::IDX_W-1:0]   idx_reg;

    // scan
    logic [UW-1:0]               scan_reg,      scan_next;
    logic                        cmp_valid_reg, cmp_valid_next;
    logic [TAW-1:0]              cmp_idx_reg,   cmp_idx_next;
    logic                        found_reg,     found_next;
    logic [TAW-1:0]              slot_reg,      slot_next;
    logic [ahct_pkg::CNT_W-1:0]  cnt_reg,       cnt_next;

    // running state
    logic [UW-1:0]               used_reg,      used_next;
    logic [FW-1:0]               fill_reg,      fill_next;
    logic [ahct_pkg::CNT_W-1:0]  drop_reg,      drop_next;

    // result register
    logic                        rsp_valid_reg, rsp_valid_next;
    logic [ahct_pkg::CNT_W-1:0]  hit_reg,       hit_next;
    logic                        nc_reg,        nc_next;
    logic [ahct_pkg::ADDR_W-1:0] tdata_reg,     tdata_next;
    logic                        tvalid_reg,    tvalid_next;
    logic [ahct_pkg::LEN_W-1:0]  tlen_reg,      tlen_next;
    logic [ahct_pkg::USED_W-1:0] eused_reg,     eused_next;

    // RAM ports
    logic                        key_we, cnt_we, trc_we;
    logic [TAW-1:0]              tbl_waddr;
    logic [ahct_pkg::CNT_W-1:0]  cnt_wdata;
    logic [ahct_pkg::ADDR_W-1:0] key_rdata;
    logic [ahct_pkg::CNT_W-1:0]  cnt_rdata;
    logic [ahct_pkg::ADDR_W-1:0] trc_rdata;
    logic [TRW-1:0]              trc_raddr;

    logic                        scan_lt;
    logic                        hit_now;
    logic [31:0]                 idx_ext;
    logic [31:0]                 fill_ext;
    logic [31:0]                 used_ext;

    ahct_ram #(.WIDTH(ahct_pkg::ADDR_W), .DEPTH(TABLE_ENTRIES)) u_key_ram (
        .clk     (clk),
        .wr_en   (key_we),
        .wr_addr (tbl_waddr),
        .wr_data (addr_reg),
        .rd_addr (scan_reg[TAW-1:0]),
        .rd_data (key_rdata)
    );

    ahct_ram #(.WIDTH(ahct_pkg::CNT_W), .DEPTH(TABLE_ENTRIES)) u_cnt_ram (
        .clk     (clk),
        .wr_en   (cnt_we),
        .wr_addr (tbl_waddr),
        .wr_data (cnt_wdata),
        .rd_addr (scan_reg[TAW-1:0]),
        .rd_data (cnt_rdata)
    );

    ahct_ram #(.WIDTH(ahct_pkg::ADDR_W), .DEPTH(TRACE_DEPTH)) u_trace_ram (
        .clk     (clk),
        .wr_en   (trc_we),
        .wr_addr (fill_reg[TRW-1:0]),
        .wr_data (addr_reg),
        .rd_addr (trc_raddr),
        .rd_data (trc_rdata)
    );

    assign idx_ext   = 32'(idx_reg);
    assign trc_raddr = idx_ext[TRW-1:0];

    // one key compare per cycle; read data comes from the registered RAM port and matches cmp_idx_reg
    assign scan_lt = (scan_reg < used_reg);
    assign hit_now = cmp_valid_reg && (key_rdata == addr_reg);

    assign sts.search_done = hit_now || (!cmp_valid_reg && !scan_lt);
    assign sts.out_free    = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        scan_next      = scan_reg;
        cmp_valid_next = cmp_valid_reg;
        cmp_idx_next   = cmp_idx_reg;
        found_next     = found_reg;
        slot_next      = slot_reg;
        cnt_next       = cnt_reg;
        if (cmd.accept)
        begin
            scan_next      = '0;
            cmp_valid_next = 1'b0;
            found_next     = 1'b0;
        end
        else if (cmd.search)
        begin
            cmp_valid_next = scan_lt && !hit_now;
            cmp_idx_next   = scan_reg[TAW-1:0];
            if (scan_lt && !hit_now)
            begin
                scan_next = scan_reg + UW'(1);
            end
            if (hit_now)
            begin
                found_next = 1'b1;
                slot_next  = cmp_idx_reg;
                cnt_next   = cnt_rdata;
            end
        end
    end

    // commit and result
    always_comb
    begin
        used_next   = used_reg;
        fill_next   = fill_reg;
        drop_next   = drop_reg;
        key_we      = 1'b0;
        cnt_we      = 1'b0;
        trc_we      = 1'b0;
        tbl_waddr   = slot_reg;
        cnt_wdata   = cnt_reg + 32'd1;
        hit_next    = '0;
        nc_next     = 1'b0;
        tdata_next  = '0;
        tvalid_next = 1'b0;
        if (cmd.finish)
        begin
            unique case (op_reg)
                ahct_pkg::OP_RECORD:
                begin
                    if (found_reg)
                    begin
                        cnt_we   = 1'b1;
                        hit_next = cnt_reg + 32'd1;
                    end
                    else if (used_reg < UW'(TABLE_ENTRIES))
                    begin
                        key_we    = 1'b1;
                        cnt_we    = 1'b1;
                        tbl_waddr = used_reg[TAW-1:0];
                        cnt_wdata = 32'd1;
                        used_next = used_reg + UW'(1);
                        hit_next  = 32'd1;
                    end
                    else
                    begin
                        nc_next = 1'b1;
                    end
                    if (fill_reg < FW'(TRACE_DEPTH))
                    begin
                        trc_we    = 1'b1;
                        fill_next = fill_reg + FW'(1);
                    end
                    else
                    begin
                        drop_next = drop_reg + 32'd1;
                    end
                end
                ahct_pkg::OP_QUERY:
                begin
                    hit_next = found_reg ? cnt_reg : '0;
                end
                ahct_pkg::OP_TRACE:
                begin
                    if (idx_ext < 32'(fill_reg))
                    begin
                        tvalid_next = 1'b1;
                        tdata_next  = trc_rdata;
                    end
                end
                ahct_pkg::OP_CLEAR:
                begin
                    used_next = '0;
                    fill_next = '0;
                    drop_next = '0;
                end
                default:
                begin
                    used_next = used_reg;
                end
            endcase
        end
    end

    // report widths are the low bits of the counters
    assign fill_ext   = 32'(fill_next);
    assign used_ext   = 32'(used_next);
    assign tlen_next  = fill_ext[ahct_pkg::LEN_W-1:0];
    assign eused_next = used_ext[ahct_pkg::USED_W-1:0];

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.finish)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            fill_reg      <= '0;
            drop_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            cmp_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            scan_reg      <= '0;
        end
        else
        begin
            used_reg      <= used_next;
            fill_reg      <= fill_next;
            drop_reg      <= drop_next;
            rsp_valid_reg <= rsp_valid_next;
            cmp_valid_reg <= cmp_valid_next;
            found_reg     <= found_next;
            scan_reg      <= scan_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg   <= ahct_pkg::op_t'(op);
            addr_reg <= event_address;
            idx_reg  <= entry_index;
        end
        cmp_idx_reg <= cmp_idx_next;
        slot_reg    <= slot_next;
        cnt_reg     <= cnt_next;
        if (cmd.finish)
        begin
            hit_reg   <= hit_next;
            nc_reg    <= nc_next;
            tdata_reg <= tdata_next;
            tvalid_reg <= tvalid_next;
            tlen_reg  <= tlen_next;
            eused_reg <= eused_next;
        end
    end

    assign rsp_valid     = rsp_valid_reg;
    assign hit_count     = hit_reg;
    assign not_counted   = nc_reg;
    assign trace_data    = tdata_reg;
    assign trace_valid   = tvalid_reg;
    assign trace_length  = tlen_reg;
    assign dropped_total = drop_reg;
    assign entries_used  = eused_reg;

endmodule

FILE: rtl/address_hit_counter_trace.sv
// A record or query scans the table from slot 0 until the key matches or the used slots
// run out; a trace read fetches one entry, a clear goes straight to commit. A new beat
// is taken only back in IDLE, once the result is loaded into the result register.
// The table scan sets the rate: one key compare per cycle from the key RAM read port.
// Reset (rst_n, async low): table empty, trace empty, dropped count zero, no result.
// ----------------------------------------------------------------------------
// address_hit_counter_trace
// Profiling block: counts hits per address in a key/count table and logs
// recorded addresses in a trace buffer.
// ----------------------------------------------------------------------------
//
// Ops:
//   record - scan the table; hit bumps the count, miss inserts with count 1
//            while there is room, else flags not_counted. The address is
//            appended to the trace, or the dropped counter bumps when full.
//   query  - scan the table and report the count, zero when untracked.
//   trace  - read one trace entry; valid only below the current fill.
//   clear  - empty table and trace, zero the dropped counter.
//
// Structure:
//   ahct_ctrl - state machine: IDLE -> SEARCH/TRACE -> FINISH -> IDLE; clear skips to FINISH.
//   ahct_dp   - three RAMs (keys, counts, trace), scan pointer, counters
//               and the result register. The result register lets a new
//               request beat in while the previous result still waits.
//
// Table and trace RAMs are not cleared: only entries below the fill
// counts are ever used.
module address_hit_counter_trace #(
    parameter int unsigned TABLE_ENTRIES = ahct_pkg::TABLE_ENTRIES_DEF,
    parameter int unsigned TRACE_DEPTH   = ahct_pkg::TRACE_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // request channel
    input  logic                         req_valid,
    output logic                         req_ready,
    input  logic [ahct_pkg::OP_W-1:0]    op,
    input  logic [ahct_pkg::ADDR_W-1:0]  event_address,
    input  logic [ahct_pkg::IDX_W-1:0]   entry_index,
    // response channel
    output logic                         rsp_valid,
    input  logic                         rsp_ready,
    output logic [ahct_pkg::CNT_W-1:0]   hit_count,
    output logic                         not_counted,
    output logic [ahct_pkg::ADDR_W-1:0]  trace_data,
    output logic                         trace_valid,
    output logic [ahct_pkg::LEN_W-1:0]   trace_length,
    output logic [ahct_pkg::CNT_W-1:0]   dropped_total,
    output logic [ahct_pkg::USED_W-1:0]  entries_used
);

    ahct_pkg::dp_cmd_t cmd;
    ahct_pkg::dp_sts_t sts;

    ahct_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .op        (op),
        .sts       (sts),
        .cmd       (cmd)
    );

    ahct_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .TRACE_DEPTH   (TRACE_DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .op            (op),
        .event_address (event_address),
        .entry_index   (entry_index),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .hit_count     (hit_count),
        .not_counted   (not_counted),
        .trace_data    (trace_data),
        .trace_valid   (trace_valid),
        .trace_length  (trace_length),
        .dropped_total (dropped_total),
        .entries_used  (entries_used)
    );

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // accept, scan step and commit come from distinct states
    a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.accept, cmd.search, cmd.finish}))
        else $error("controller issued overlapping commands");

    // once a beat is taken the block is busy on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request accepted while previous item in flight");

    // an uncounted event never reports a count
    a_nc_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && not_counted) |-> (hit_count == '0))
        else $error("not_counted with non-zero hit_count");

    // a valid trace read implies a non-empty trace
    a_trace_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && trace_valid) |-> (trace_length != '0 || TRACE_DEPTH > 2047))
        else $error("trace_valid with empty trace");

endmodule

FILE: tb/address_hit_counter_trace_tb.sv
// ----------------------------------------------------------------------------
// address_hit_counter_trace_tb
// Self-checking bench for the address hit counter with trace buffer: a short
// directed table (empty block, extreme addresses, reads past the fill, clear),
// then random beats that fill the key table and overflow the trace, then mixed
// traffic with clears. Every result beat is checked field by field against an
// in-bench profile predictor; both handshakes see random idle bursts until the last stretch.
// ----------------------------------------------------------------------------
module address_hit_counter_trace_tb;

    localparam int POOL_N    = 200;   // more distinct keys than table slots
    localparam int HOLD_AT   = 300;   // result count at which the long stall starts
    localparam int HOLD_LEN  = 400;   // cycles of receiver hold-off
    localparam int DRAIN_CYC = 150;   // drain window, longer than the worst table scan

    // one result beat, as the block reports it
    typedef struct packed {
        logic [ahct_pkg::CNT_W-1:0]  hit_count;
        logic                        not_counted;
        logic [ahct_pkg::ADDR_W-1:0] trace_data;
        logic                        trace_valid;
        logic [ahct_pkg::LEN_W-1:0]  trace_length;
        logic [ahct_pkg::CNT_W-1:0]  dropped_total;
        logic [ahct_pkg::USED_W-1:0] entries_used;
    } profile_report_t;

    // one row of the directed table; known rows carry a hand-written result
    typedef struct {
        ahct_pkg::op_t   code;
        logic [31:0]     address;
        logic [9:0]      index;
        bit              known;
        profile_report_t report;
    } stim_row_t;

    logic                        clk;
    logic                        rst_n;
    logic                        req_valid;
    logic                        req_ready;
    ahct_pkg::op_t               op;
    logic [ahct_pkg::ADDR_W-1:0] event_address;
    logic [ahct_pkg::IDX_W-1:0]  entry_index;
    logic                        rsp_valid;
    logic                        rsp_ready;
    logic [ahct_pkg::CNT_W-1:0]  hit_count;
    logic                        not_counted;
    logic [ahct_pkg::ADDR_W-1:0] trace_data;
    logic                        trace_valid;
    logic [ahct_pkg::LEN_W-1:0]  trace_length;
    logic [ahct_pkg::CNT_W-1:0]  dropped_total;
    logic [ahct_pkg::USED_W-1:0] entries_used;

    // predictor state: shadow of the key/count table and the trace buffer
    logic [ahct_pkg::ADDR_W-1:0] key_mem   [ahct_pkg::TABLE_ENTRIES_DEF];
    logic [ahct_pkg::CNT_W-1:0]  count_mem [ahct_pkg::TABLE_ENTRIES_DEF];
    logic [ahct_pkg::ADDR_W-1:0] trace_mem [ahct_pkg::TRACE_DEPTH_DEF];
    int                          n_used;
    int                          n_fill;
    logic [ahct_pkg::CNT_W-1:0]  n_dropped;

    profile_report_t             pending_reports [$];
    logic [ahct_pkg::ADDR_W-1:0] addr_pool [POOL_N];
    stim_row_t                   directed_rows [23];

    // run bookkeeping
    int  n_beats;
    int  n_results;
    int  n_mismatch;
    int  n_records;
    int  n_uncounted;
    int  n_drop_events;
    int  n_valid_reads;
    int  n_clears;
    int  max_used;
    bit  calm;        // last stretch: no idling on either side
    bit  hold_rsp;    // long receiver hold-off in progress
    int  stall_left;

    address_hit_counter_trace u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .op            (op),
        .event_address (event_address),
        .entry_index   (entry_index),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .hit_count     (hit_count),
        .not_counted   (not_counted),
        .trace_data    (trace_data),
        .trace_valid   (trace_valid),
        .trace_length  (trace_length),
        .dropped_total (dropped_total),
        .entries_used  (entries_used)
    );

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Generous ceiling on run time; reaching it reports a failure.
    initial
    begin
        #6000000;
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor: applies one request beat to the shadow state and returns
    // the result the block should report for it.
    // ------------------------------------------------------------------
    function automatic profile_report_t predict_report(ahct_pkg::op_t code,
                                                       logic [31:0] addr,
                                                       logic [9:0] idx);
        profile_report_t r;
        int              slot;
        r = '0;
        // linear search; slot == n_used means the key is not tracked
        slot = n_used;
        for (int i = 0; i < n_used; i++)
            if (key_mem[i] == addr && slot == n_used)
                slot = i;
        case (code)
            ahct_pkg::OP_RECORD:
            begin
                n_records++;
                if (slot < n_used)
                begin
                    count_mem[slot] = count_mem[slot] + 1'b1;   // wraps mod 2^32
                    r.hit_count     = count_mem[slot];
                end
                else if (n_used < ahct_pkg::TABLE_ENTRIES_DEF)
                begin
                    key_mem[n_used]   = addr;
                    count_mem[n_used] = 1;
                    n_used++;
                    r.hit_count = 1;
                end
                else
                begin
                    // table full on a miss: flagged, count reads as zero
                    r.not_counted = 1'b1;
                    n_uncounted++;
                end
                // trace append happens whether or not the event was counted
                if (n_fill < ahct_pkg::TRACE_DEPTH_DEF)
                begin
                    trace_mem[n_fill] = addr;
                    n_fill++;
                end
                else
                begin
                    n_dropped = n_dropped + 1'b1;
                    n_drop_events++;
                end
            end
            ahct_pkg::OP_QUERY:
                if (slot < n_used)
                    r.hit_count = count_mem[slot];
            ahct_pkg::OP_TRACE:
                if (idx < n_fill)
                begin
                    r.trace_data  = trace_mem[idx];
                    r.trace_valid = 1'b1;
                    n_valid_reads++;
                end
            ahct_pkg::OP_CLEAR:
            begin
                n_used    = 0;
                n_fill    = 0;
                n_dropped = '0;
                n_clears++;
            end
        endcase
        r.trace_length  = ahct_pkg::LEN_W'(n_fill);
        r.dropped_total = n_dropped;
        r.entries_used  = ahct_pkg::USED_W'(n_used);
        if (n_used > max_used)
            max_used = n_used;
        return r;
    endfunction

    function automatic profile_report_t report_of(logic [31:0] hits, logic nc,
                                                  logic [31:0] tdata, logic tvalid,
                                                  int tlen, logic [31:0] drops, int used);
        profile_report_t r;
        r.hit_count     = hits;
        r.not_counted   = nc;
        r.trace_data    = tdata;
        r.trace_valid   = tvalid;
        r.trace_length  = ahct_pkg::LEN_W'(tlen);
        r.dropped_total = drops;
        r.entries_used  = ahct_pkg::USED_W'(used);
        return r;
    endfunction

    // Mostly pool keys so entries get hit again; a hot few build counts,
    // and some fully random ones miss.
    function automatic logic [31:0] pick_address();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2)
            return $urandom;
        if (r < 4)
            return addr_pool[$urandom_range(0, 7)];
        return addr_pool[$urandom_range(0, POOL_N - 1)];
    endfunction

    // ------------------------------------------------------------------
    // Request side. Fields change at the falling edge; the beat is taken
    // at the rising edge where req_ready is seen high.
    // ------------------------------------------------------------------
    task automatic send_beat(ahct_pkg::op_t code, logic [31:0] addr, logic [9:0] idx,
                             bit known, profile_report_t typed);
        profile_report_t want;
        int              gap;
        gap = 0;
        if (!calm && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 11);
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid     <= 1'b1;
        op            <= code;
        event_address <= addr;
        entry_index   <= idx;
        do
            @(posedge clk);
        while (!req_ready);
        // predictor always runs so its state tracks the block
        want = predict_report(code, addr, idx);
        if (known)
            want = typed;
        pending_reports.push_back(want);
        n_beats++;
    endtask

    task automatic random_beat(int clear_pct, int record_pct);
        int            r;
        ahct_pkg::op_t code;
        logic [31:0]   addr;
        logic [9:0]    idx;
        r    = $urandom_range(0, 99);
        addr = pick_address();
        idx  = 10'($urandom_range(0, ahct_pkg::TRACE_DEPTH_DEF - 1));
        if (r < clear_pct)
            code = ahct_pkg::OP_CLEAR;
        else if (r < clear_pct + record_pct)
            code = ahct_pkg::OP_RECORD;
        else if ($urandom_range(0, 1) == 0)
            code = ahct_pkg::OP_QUERY;
        else
        begin
            code = ahct_pkg::OP_TRACE;
            // mostly read inside the fill, sometimes anywhere
            if (n_fill > 0 && $urandom_range(0, 3) != 0)
                idx = 10'($urandom_range(0, n_fill - 1));
        end
        send_beat(code, addr, idx, 1'b0, '0);
    endtask

    // ------------------------------------------------------------------
    // Response side: random stall bursts, plus one long hold-off.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n || hold_rsp)
            rsp_ready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            rsp_ready  <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 7) == 0)
        begin
            stall_left <= $urandom_range(0, 10);   // stall starts now and runs on while stall_left counts down
            rsp_ready  <= 1'b0;
        end
        else
            rsp_ready <= 1'b1;
    end

    // Long back-pressure: the block's result register fills and it must
    // hold req_ready low while the sender keeps its beat offered.
    initial
    begin
        hold_rsp = 1'b0;
        wait (n_results >= HOLD_AT);
        @(posedge clk);
        hold_rsp = 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
        hold_rsp = 1'b0;
    end

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            n_mismatch++;
            if (n_mismatch <= 10)
                $display("mismatch on result beat %0d: %s expected %h got %h",
                         n_results, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin : result_check
        profile_report_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_reports.size() == 0)
            begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("result beat %0d arrived with nothing outstanding", n_results);
            end
            else
            begin
                want = pending_reports.pop_front();
                check_field("hit_count",     want.hit_count,     hit_count);
                check_field("not_counted",   32'(want.not_counted),  32'(not_counted));
                check_field("trace_data",    want.trace_data,    trace_data);
                check_field("trace_valid",   32'(want.trace_valid),  32'(trace_valid));
                check_field("trace_length",  32'(want.trace_length), 32'(trace_length));
                check_field("dropped_total", want.dropped_total, dropped_total);
                check_field("entries_used",  32'(want.entries_used), 32'(entries_used));
            end
            n_results++;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        int guard;
        rst_n         = 1'b0;
        req_valid     = 1'b0;
        op            = ahct_pkg::OP_RECORD;
        event_address = '0;
        entry_index   = '0;
        calm          = 1'b0;
        n_used        = 0;
        n_fill        = 0;
        n_dropped     = '0;

        // key pool: extremes first, rest random
        addr_pool[0] = 32'h0000_0000;
        addr_pool[1] = 32'hFFFF_FFFF;
        addr_pool[2] = 32'h8000_0000;
        addr_pool[3] = 32'h7FFF_FFFF;
        for (int i = 4; i < POOL_N; i++)
            addr_pool[i] = $urandom;

        // Directed table. Empty block, extreme keys, hit/miss, reads in and
        // past the fill, clear and restart. Rows with known = 0 go to the
        // predictor.
        directed_rows = '{
            '{ahct_pkg::OP_QUERY,  32'h1234_5678, 10'd0,    1'b1,
              report_of(0, 0, 0, 0, 0, 0, 0)},
            '{ahct_pkg::OP_TRACE,  32'h0000_0000, 10'd0,    1'b1,
              report_of(0, 0, 0, 0, 0, 0, 0)},
            '{ahct_pkg::OP_TRACE,  32'hFFFF_FFFF, 10'd1023, 1'b1,
              report_of(0, 0, 0, 0, 0, 0, 0)},
            '{ahct_pkg::OP_RECORD, 32'hFFFF_FFFF, 10'd0,    1'b1,
              report_of(1, 0, 0, 0, 1, 0, 1)},
            '{ahct_pkg::OP_RECORD, 32'h0000_0000, 10'd0,    1'b1,
              report_of(1, 0, 0, 0, 2, 0, 2)},
            '{ahct_pkg::OP_RECORD, 32'hFFFF_FFFF, 10'd0,    1'b1,
              report_of(2, 0, 0, 0, 3, 0, 2)},
            '{ahct_pkg::OP_QUERY,  32'hFFFF_FFFF, 10'd0,    1'b1,
              report_of(2, 0, 0, 0, 3, 0, 2)},
            '{ahct_pkg::OP_QUERY,  32'h0000_0000, 10'd0,    1'b1,
              report_of(1, 0, 0, 0, 3, 0, 2)},
            '{ahct_pkg::OP_TRACE,  32'h0000_0000, 10'd0,    1'b1,
              report_of(0, 0, 32'hFFFF_FFFF, 1, 3, 0, 2)},
            '{ahct_pkg::OP_TRACE,  32'hFFFF_FFFF, 10'd1,    1'b1,
              report_of(0, 0, 0, 1, 3, 0, 2)},
            '{ahct_pkg::OP_TRACE,  32'h0000_0000, 10'd3,    1'b1,
              report_of(0, 0, 0, 0, 3, 0, 2)},
            '{ahct_pkg::OP_QUERY,  32'hDEAD_BEEF, 10'd0,    1'b1,
              report_of(0, 0, 0, 0, 3, 0, 2)},
            '{ahct_pkg::OP_RECORD, 32'hA5A5_A5A5, 10'd1023, 1'b1,
              report_of(1, 0, 0, 0, 4, 0, 3)},
            '{ahct_pkg::OP_RECORD, 32'h5A5A_5A5A, 10'd1023, 1'b0, '0},
            '{ahct_pkg::OP_TRACE,  32'h0000_0000, 10'd4,    1'b0, '0},
            '{ahct_pkg::OP_CLEAR,  32'hFFFF_FFFF, 10'd1023, 1'b1,
              report_of(0, 0, 0, 0, 0, 0, 0)},
            '{ahct_pkg::OP_QUERY,  32'hFFFF_FFFF, 10'd0,    1'b1,
              report_of(0, 0, 0, 0, 0, 0, 0)},
            '{ahct_pkg::OP_TRACE,  32'h0000_0000, 10'd0,    1'b1,
              report_of(0, 0, 0, 0, 0, 0, 0)},
            '{ahct_pkg::OP_RECORD, 32'h8000_0000, 10'd0,    1'b1,
              report_of(1, 0, 0, 0, 1, 0, 1)},
            '{ahct_pkg::OP_RECORD, 32'h7FFF_FFFF, 10'd512,  1'b0, '0},
            '{ahct_pkg::OP_QUERY,  32'h8000_0000, 10'd0,    1'b0, '0},
            '{ahct_pkg::OP_RECORD, 32'h8000_0000, 10'd0,    1'b0, '0},
            '{ahct_pkg::OP_CLEAR,  32'h0000_0000, 10'd0,    1'b1,
              report_of(0, 0, 0, 0, 0, 0, 0)}
        };

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_beat(directed_rows[i].code, directed_rows[i].address,
                      directed_rows[i].index, directed_rows[i].known,
                      directed_rows[i].report);

        // Record-heavy run without clears: the table fills (misses then go
        // uncounted) and the trace overflows into the dropped counter.
        guard = 0;
        while (!(n_fill == ahct_pkg::TRACE_DEPTH_DEF && n_drop_events >= 40)
               && guard < 3000)
        begin
            random_beat(0, 80);
            guard++;
        end

        // Mixed traffic with occasional clears.
        repeat (200) random_beat(2, 60);

        // Last stretch at full rate on both sides.
        calm = 1'b1;
        repeat (100) random_beat(2, 60);

        @(negedge clk);
        req_valid <= 1'b0;

        while (pending_reports.size() != 0)
            @(posedge clk);
        // any stray result beat in this window is caught by the checker
        repeat (DRAIN_CYC) @(posedge clk);

        $display("%0d request beats, %0d result beats: %0d records, %0d uncounted misses,",
                 n_beats, n_results, n_records, n_uncounted);
        $display("%0d trace drops, %0d valid trace reads, %0d clears, peak table use %0d",
                 n_drop_events, n_valid_reads, n_clears, max_used);
        if (n_mismatch == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
